### rtl/sfcd_pkg.sv
// Package: shared types, constants and the CRC-16 byte update for the deframer.
`timescale 1ns / 1ps
package sfcd_pkg;

  localparam int unsigned MaxPayload = 1024;

  localparam logic [7:0]  SyncFirst  = 8'h45;  // 'E'
  localparam logic [7:0]  SyncSecond = 8'h58;  // 'X'
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcSubst   = 16'hAAAA;
  localparam logic [15:0] MaxPayloadW = 16'(MaxPayload);

  localparam int unsigned HdrBytes = 10;
  localparam int unsigned PosW     = 4;
  localparam int unsigned HdrIdxW  = 4;
  localparam int unsigned LenW     = 11;

  localparam logic [PosW-1:0] PosHunt     = 4'd0;
  localparam logic [PosW-1:0] PosSync1    = 4'd1;
  localparam logic [PosW-1:0] PosHdrStart = 4'd2;
  localparam logic [PosW-1:0] PosHdrEnd   = 4'd12;
  localparam logic [PosW-1:0] PosPastHdr  = 4'd13;

  localparam int unsigned TdataOutW = 88;
  localparam int unsigned TuserOutW = 3;

  typedef struct packed {
    logic            payload_valid;
    logic [7:0]      payload_byte;
    logic            frame_end;
    logic            frame_ok;
    logic            length_error;
    logic [7:0]      message_id;
    logic [15:0]     serial_number;
    logic [7:0]      first_param;
    logic [15:0]     second_param;
    logic [15:0]     third_param;
    logic [LenW-1:0] payload_length;
  } result_t;

  // Byte-wise CCITT CRC-16 update (swap, xor, shift-fold form)
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

### rtl/sfcd_parser.sv
// Frame parser: sync hunt, header capture, payload forwarding and CRC check.
`timescale 1ns / 1ps
module sfcd_parser import sfcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output result_t    result_o
);

  logic              in_frame_q, in_frame_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        trailer_q, trailer_d;
  logic [7:0]        hdr_q [HdrBytes];
  logic              hdr_we;
  logic [HdrIdxW-1:0] hdr_idx;

  logic [15:0]       len;
  logic [LenW-1:0]   len_sat;
  logic [LenW-1:0]   rem_eff;
  logic [LenW-1:0]   rem_dec;
  logic [15:0]       crc_fin;
  result_t           hdr_res;

  assign hdr_idx = pos_q - PosHdrStart;
  assign len     = {hdr_q[9], hdr_q[8]};
  assign len_sat = (len[15:LenW] != '0) ? {LenW{1'b1}} : len[LenW-1:0];
  // On the first byte past the header the count is loaded with length plus trailer
  assign rem_eff = (pos_q == PosHdrEnd) ? (len[LenW-1:0] + LenW'(2)) : rem_q;
  assign rem_dec = rem_eff - LenW'(1);
  assign crc_fin = (crc_q == CrcInit) ? CrcSubst : crc_q;

  always_comb begin
    hdr_res                = '0;
    hdr_res.message_id     = hdr_q[2];
    hdr_res.serial_number  = {hdr_q[1], hdr_q[0]};
    hdr_res.first_param    = hdr_q[3];
    hdr_res.second_param   = {hdr_q[5], hdr_q[4]};
    hdr_res.third_param    = {hdr_q[7], hdr_q[6]};
    hdr_res.payload_length = len_sat;
  end

  always_comb begin
    result_o   = '0;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    crc_d      = crc_q;
    trailer_d  = trailer_q;
    hdr_we     = 1'b0;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (data_byte_i == SyncFirst && pos_q == PosHunt) begin
          pos_d = PosSync1;
        end else if (data_byte_i == SyncSecond && pos_q == PosSync1) begin
          pos_d      = PosHdrStart;
          in_frame_d = 1'b1;
          crc_d      = CrcInit;
        end else begin
          pos_d = PosHunt;
        end
      end else if (pos_q < PosHdrEnd) begin
        hdr_we = 1'b1;
        crc_d  = crc_update(crc_q, data_byte_i);
        pos_d  = pos_q + PosW'(1);
      end else if (pos_q == PosHdrEnd && len > MaxPayloadW) begin
        // oversized frame: drop this byte and report the header
        result_o              = hdr_res;
        result_o.length_error = 1'b1;
        in_frame_d = 1'b0;
        pos_d      = PosHunt;
        rem_d      = '0;
      end else if (rem_eff == '0) begin
        in_frame_d = 1'b0;
        pos_d      = PosHunt;
        rem_d      = '0;
      end else begin
        rem_d = rem_dec;
        pos_d = PosPastHdr;
        if (rem_dec >= LenW'(2)) begin
          crc_d                  = crc_update(crc_q, data_byte_i);
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = data_byte_i;
        end else if (rem_dec == LenW'(1)) begin
          trailer_d = data_byte_i;
        end else begin
          result_o           = hdr_res;
          result_o.frame_end = 1'b1;
          result_o.frame_ok  = (crc_fin == {trailer_q, data_byte_i});
          in_frame_d = 1'b0;
          pos_d      = PosHunt;
          rem_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= PosHunt;
      rem_q      <= '0;
      crc_q      <= CrcInit;
      trailer_q  <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      crc_q      <= crc_d;
      trailer_q  <= trailer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= data_byte_i;
    end
  end

endmodule

### rtl/sfcd_out_buf.sv
// Output register with skid stage; the input side stalls only once both are full.
`timescale 1ns / 1ps
module sfcd_out_buf import sfcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_result_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o
);

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    push;
  logic    pop;

  assign in_ready_o   = !skid_valid_q;
  assign push         = in_valid_i && !skid_valid_q;
  assign pop          = out_valid_q && out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= in_result_i;
      end else begin
        skid_q <= in_result_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

endmodule

### rtl/sync_frame_crc_deframer_top.sv
// Top level: sync-framed message deframer with CRC-16 trailer check.
//
// Slave stream carries one received serial byte per transaction in s_axis_tdata.
// The block hunts for the sync pair 'E','X', captures the 10-byte header and
// forwards payload bytes; each accepted byte yields exactly one master transaction.
// m_axis_tuser flags a forwarded payload byte, a good CRC and an oversized length;
// m_axis_tlast marks the transaction of the last CRC byte, carrying header fields.
// Results are registered in the output register, or the skid register on a stall.
// Throughput: one byte per cycle while s_axis_tready is high; the parser never stalls.
// Reset puts the parser back into sync hunt with the CRC at FFFF and empties the
// output stages. When the receiver stalls, one result waits in the output register
// and one more in a skid register; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
module sync_frame_crc_deframer_top import sfcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] payload_byte, [15:8] message_id, [31:16] serial_number,
  // [39:32] first_param, [55:40] second_param, [71:56] third_param,
  // [82:72] payload_length, [87:83] zero
  output logic [TdataOutW-1:0] m_axis_tdata,
  // [0] payload_valid, [1] frame_ok, [2] length_error
  output logic [TuserOutW-1:0] m_axis_tuser,
  output logic                 m_axis_tlast    // frame_end
);

  logic    accept;
  result_t parse_res;
  result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  sfcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .result_o    (parse_res)
  );

  sfcd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_result_i  (parse_res),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_res)
  );

  assign m_axis_tdata = {5'b00000,
                         out_res.payload_length,
                         out_res.third_param,
                         out_res.second_param,
                         out_res.first_param,
                         out_res.serial_number,
                         out_res.message_id,
                         out_res.payload_byte};
  assign m_axis_tuser = {out_res.length_error, out_res.frame_ok, out_res.payload_valid};
  assign m_axis_tlast = out_res.frame_end;

endmodule
